/* hw/rtl/conv3x3_clamp_filter_defines.svh */
// ----------------------------------------------------------------------------
// conv3x3_clamp_filter assertion macros
// Shared assertion forms for the filter's checker.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_CLAMP_FILTER_DEFINES_SVH
`define CONV3X3_CLAMP_FILTER_DEFINES_SVH

// Same-cycle implication.
`define C3CF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c3cf: implication check failed");

// Next-cycle implication, not disabled by reset.
`define C3CF_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("c3cf: next-cycle check failed");

`endif

/* hw/rtl/c3cf_pkg.sv */
// ----------------------------------------------------------------------------
// c3cf_pkg
// Types and constants shared by the 3x3 convolution filter modules.
// ----------------------------------------------------------------------------
package c3cf_pkg;

  localparam int PIX_W         = 8;
  localparam int DIM_W         = 11;
  localparam int POS_W         = 10;
  localparam int COEF_W        = 16;
  localparam int ROW_W         = 3 * COEF_W;
  localparam int PROD_W        = PIX_W + 1 + COEF_W;
  localparam int ACC_W         = 28;
  localparam int CS_W          = 20;
  localparam int TAPS          = 9;
  localparam int TAP_W         = 4;
  localparam int QDEPTH        = 2;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int LAPLACE_ADD   = 195;
  localparam int PIX_MAX       = 255;
  localparam int MIN_DIM       = 3;
  localparam int BORDER        = 3;

  typedef enum logic [2:0] {
    REG_COEF_TOP  = 3'd0,
    REG_COEF_MID  = 3'd1,
    REG_COEF_BOT  = 3'd2,
    REG_DIV_SUM   = 3'd3,
    REG_LAPLACE   = 3'd4,
    REG_WIDTH     = 3'd5,
    REG_HEIGHT    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [PIX_W-1:0] out_value;
  } out_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] coef_top;
    logic [ROW_W-1:0] coef_mid;
    logic [ROW_W-1:0] coef_bot;
    logic             div_en;
    logic             lap_en;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] win;
    logic [DIM_W-1:0]           cx;
    logic [DIM_W-1:0]           cy;
    logic                       border;
  } item_t;

endpackage

/* hw/rtl/c3cf_front.sv */
// ----------------------------------------------------------------------------
// c3cf_front
// Pixel intake: position counters, two line stores and the 3x3 window.
// ----------------------------------------------------------------------------
module c3cf_front
  import c3cf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word,
  output logic     q_push,
  input  logic     q_full,
  output item_t    q_item
);

  localparam int AW = $clog2(MAX_WIDTH);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [DIM_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [DIM_W-1:0] x_r, y_r, xs, ys;
  logic [PIX_W-1:0] pix_r, up1_r, up2_r;
  logic [TAPS-1:0][PIX_W-1:0] win_r, win_nxt;
  logic [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [PIX_W-1:0] mem_b [MAX_WIDTH];
  logic             accept, emit, go;

  assign full   = (state_r != F_IDLE);
  assign accept = push && (state_r == F_IDLE);
  assign emit   = (x_r >= DIM_W'(2)) && (y_r >= DIM_W'(2));
  assign go     = (state_r == F_UPD) && (!emit || !q_full);
  assign q_push = go && emit;

  always_comb begin
    xs = in_word.frame_start ? '0 : col_r;
    ys = in_word.frame_start ? '0 : row_r;
    if (xs >= cfg.width) begin
      xs = '0;
    end
    if (ys >= cfg.height) begin
      ys = '0;
    end
  end

  // Shift left by one column; the newest column enters on the right.
  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = up2_r;
    win_nxt[5] = up1_r;
    win_nxt[8] = pix_r;
  end

  always_comb begin
    q_item.win    = win_nxt;
    q_item.cx     = x_r - DIM_W'(1);
    q_item.cy     = y_r - DIM_W'(1);
    q_item.border = (q_item.cx <= DIM_W'(BORDER)) ||
                    (q_item.cx >= cfg.width - DIM_W'(BORDER)) ||
                    (q_item.cy <= DIM_W'(BORDER)) ||
                    (q_item.cy >= cfg.height - DIM_W'(BORDER));
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_UPD;
        end
      end
      F_UPD: begin
        if (go) begin
          state_nxt = F_IDLE;
          col_nxt   = x_r + DIM_W'(1);
          row_nxt   = y_r;
          if (col_nxt >= cfg.width) begin
            col_nxt = '0;
            row_nxt = y_r + DIM_W'(1);
            if (row_nxt >= cfg.height) begin
              row_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (go) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= xs;
      y_r   <= ys;
      pix_r <= in_word.pixel;
      up1_r <= mem_a[AW'(xs)];
      up2_r <= mem_b[AW'(xs)];
    end
    if (go) begin
      mem_a[AW'(x_r)] <= pix_r;
      mem_b[AW'(x_r)] <= up1_r;
    end
  end

endmodule

/* hw/rtl/c3cf_fifo.sv */
// ----------------------------------------------------------------------------
// c3cf_fifo
// Short window queue between the intake and the arithmetic back end.
// ----------------------------------------------------------------------------
module c3cf_fifo
  import c3cf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  q_full,
  input  logic  rd_en,
  output logic  q_empty,
  output item_t rd_item
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         slot_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign q_full  = (cnt_r == CW'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_item = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wp_r] <= wr_item;
    end
  end

endmodule

/* hw/rtl/c3cf_back.sv */
// ----------------------------------------------------------------------------
// c3cf_back
// Multiply-accumulate over the window, serial divide, offset, clamp, output.
// ----------------------------------------------------------------------------
module c3cf_back
  import c3cf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  item_t     q_item,
  output logic      q_pop,
  output logic      out_valid,
  output out_word_t out_word,
  input  logic      pop
);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_MAC  = 7'b0000010,
    B_CHK  = 7'b0000100,
    B_DIV  = 7'b0001000,
    B_SGN  = 7'b0010000,
    B_FIN  = 7'b0100000,
    B_OUT  = 7'b1000000
  } bstate_t;

  localparam int DC_W = $clog2(ACC_W);

  bstate_t                    state_r;
  item_t                      item_r;
  logic [TAP_W-1:0]           tap_r;
  logic signed [COEF_W-1:0]   coef [TAPS];
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r, val_r;
  logic signed [CS_W-1:0]     csum_r;
  logic [ACC_W-1:0]           dvd_r;
  logic [CS_W-1:0]            dvs_r, rem_r, rem_sh;
  logic [DC_W-1:0]            cnt_r;
  logic                       neg_r, out_valid_r;
  logic [PIX_W-1:0]           res_r;
  logic signed [ACC_W:0]      fin;
  logic [PIX_W-1:0]           fin_pix;
  out_word_t                  out_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef[c]   = $signed(cfg.coef_top[c*COEF_W +: COEF_W]);
      coef[3+c] = $signed(cfg.coef_mid[c*COEF_W +: COEF_W]);
      coef[6+c] = $signed(cfg.coef_bot[c*COEF_W +: COEF_W]);
    end
  end

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign rem_sh    = {rem_r[CS_W-2:0], dvd_r[ACC_W-1]};

  always_comb begin
    fin = {val_r[ACC_W-1], val_r};
    if (cfg.lap_en) begin
      fin = fin + (ACC_W+1)'(LAPLACE_ADD);
    end
    if (fin < 0) begin
      fin_pix = '0;
    end else if (fin > (ACC_W+1)'(PIX_MAX)) begin
      fin_pix = PIX_W'(PIX_MAX);
    end else begin
      fin_pix = fin[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            state_r <= q_item.border ? B_OUT : B_MAC;
          end
        end
        B_MAC: begin
          if (tap_r == TAP_W'(TAPS)) begin
            state_r <= B_CHK;
          end
        end
        B_CHK: begin
          state_r <= (cfg.div_en && csum_r != '0) ? B_DIV : B_FIN;
        end
        B_DIV: begin
          if (cnt_r == DC_W'(ACC_W - 1)) begin
            state_r <= B_SGN;
          end
        end
        B_SGN: begin
          state_r <= B_FIN;
        end
        B_FIN: begin
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        item_r <= q_item;
        tap_r  <= '0;
        prod_r <= '0;
        acc_r  <= '0;
        csum_r <= '0;
        res_r  <= '0;
      end
      B_MAC: begin
        acc_r <= acc_r + ACC_W'(prod_r);
        if (tap_r != TAP_W'(TAPS)) begin
          prod_r <= $signed({1'b0, item_r.win[tap_r]}) * coef[tap_r];
          csum_r <= csum_r + CS_W'(coef[tap_r]);
          tap_r  <= tap_r + TAP_W'(1);
        end
      end
      B_CHK: begin
        val_r <= acc_r;
        dvd_r <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        dvs_r <= csum_r[CS_W-1] ? CS_W'(-csum_r) : CS_W'(csum_r);
        neg_r <= acc_r[ACC_W-1] ^ csum_r[CS_W-1];
        rem_r <= '0;
        cnt_r <= '0;
      end
      B_DIV: begin
        // One restoring step per cycle; quotient bits shift in at the bottom.
        if (rem_sh >= dvs_r) begin
          rem_r <= rem_sh - dvs_r;
          dvd_r <= {dvd_r[ACC_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dvd_r <= {dvd_r[ACC_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + DC_W'(1);
      end
      B_SGN: begin
        val_r <= neg_r ? -$signed(dvd_r) : $signed(dvd_r);
      end
      B_FIN: begin
        res_r <= fin_pix;
      end
      B_OUT: begin
        if (!out_valid_r) begin
          out_r.out_x     <= item_r.cx[POS_W-1:0];
          out_r.out_y     <= item_r.cy[POS_W-1:0];
          out_r.out_value <= res_r;
        end
      end
      default: begin
        res_r <= '0;
      end
    endcase
  end

endmodule

/* hw/rtl/conv3x3_clamp_filter.sv */
// ----------------------------------------------------------------------------
// conv3x3_clamp_filter
// Streaming 3x3 convolution of 8-bit grayscale pixels with clamping.
// ----------------------------------------------------------------------------
// Intake: a pixel is accepted only while idle; the update state then writes the
// line stores back and shifts the window, waiting while the queue is full. The
// back end sends a border-band word straight out; an inner word passes the MAC
// and check states, divide and sign when dividing by a nonzero sum, then finish.
// Reset (rst_n low, synchronous) restores the register defaults, zeroes the
// counters and window and empties the queue; the line stores are not reset.
// ----------------------------------------------------------------------------
module conv3x3_clamp_filter
  import c3cf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Pixel input, queue style.
  input  logic                 push,
  output logic                 full,
  input  in_word_t             in_word,
  // Result output, queue style.
  output logic                 empty,
  input  logic                 pop,
  output out_word_t            out_word,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  // Configuration registers. Writes are always taken; an unknown index
  // completes the handshake and changes nothing.
  logic [ROW_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;
  logic             div_en_r, lap_en_r;
  logic [DIM_W-1:0] width_r, height_r;
  cfg_t             cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r <= '0;
      coef_mid_r <= ROW_W'(65536);
      coef_bot_r <= '0;
      div_en_r   <= 1'b0;
      lap_en_r   <= 1'b0;
      width_r    <= DIM_W'(640);
      height_r   <= DIM_W'(480);
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF_TOP: coef_top_r <= cfg_data;
        REG_COEF_MID: coef_mid_r <= cfg_data;
        REG_COEF_BOT: coef_bot_r <= cfg_data;
        REG_DIV_SUM:  div_en_r   <= cfg_data[0];
        REG_LAPLACE:  lap_en_r   <= cfg_data[0];
        REG_WIDTH:    width_r    <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   height_r   <= cfg_data[DIM_W-1:0];
        default: begin
          div_en_r <= div_en_r;
        end
      endcase
    end
  end

  // Frame dimensions are saturated to MIN_DIM..MAX_WIDTH, the width range the line stores support.
  always_comb begin
    cfg.coef_top = coef_top_r;
    cfg.coef_mid = coef_mid_r;
    cfg.coef_bot = coef_bot_r;
    cfg.div_en   = div_en_r;
    cfg.lap_en   = lap_en_r;
    if (width_r < DIM_W'(MIN_DIM)) begin
      cfg.width = DIM_W'(MIN_DIM);
    end else if (32'(width_r) > MAX_WIDTH) begin
      cfg.width = DIM_W'(MAX_WIDTH);
    end else begin
      cfg.width = width_r;
    end
    if (height_r < DIM_W'(MIN_DIM)) begin
      cfg.height = DIM_W'(MIN_DIM);
    end else if (32'(height_r) > MAX_WIDTH) begin
      cfg.height = DIM_W'(MAX_WIDTH);
    end else begin
      cfg.height = height_r;
    end
  end

  logic  q_push, q_full, q_pop, q_empty, out_valid;
  item_t q_wr_item, q_rd_item;

  // The front end classifies each window as border or inner and queues it.
  c3cf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_item  (q_wr_item)
  );

  c3cf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_item (q_rd_item)
  );

  // The back end computes each window and holds the finished word in its
  // output register until it is popped.
  c3cf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_word  (out_word),
    .pop       (pop)
  );

  assign empty = !out_valid;

endmodule

/* hw/rtl/c3cf_checker.sv */
// ----------------------------------------------------------------------------
// c3cf_checker
// Port-level checks for the 3x3 convolution filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv3x3_clamp_filter_defines.svh"

module c3cf_checker
  import c3cf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_word_t out_word,
  input logic      cfg_ready
);

  `C3CF_ASSERT_NXT(a_reset_empty, clk, !rst_n, empty)
  `C3CF_ASSERT_NXT(a_reset_ready, clk, !rst_n, !full)
  `C3CF_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
  `C3CF_ASSERT_NXT(a_word_holds, clk, rst_n && !empty && !pop, empty == 1'b0 && $stable(out_word))

endmodule

bind conv3x3_clamp_filter c3cf_checker u_c3cf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_word  (out_word),
  .cfg_ready (cfg_ready)
);
